### design/fbde_pkg.sv
// shared types, constants and font table for the framebuffer draw engine
package fbde_pkg;

   localparam int COLUMNS     = 122;
   localparam int PAGES       = 4;
   localparam int GLYPH_WIDTH = 6;
   localparam int ROWS        = PAGES * 8;
   localparam int COL_AW      = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      OP_BLIT  = 3'd0,
      OP_CHAR  = 3'd1,
      OP_BAND  = 3'd2,
      OP_HLINE = 3'd3,
      OP_VLINE = 3'd4,
      OP_FILL  = 3'd5,
      OP_READ  = 3'd6,
      OP_NOP   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_XOR    = 2'd2,
      MODE_INVERT = 2'd3
   } mode_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_CLIPPED  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_READ,
      S_MODIFY,
      S_FINISH
   } state_type;

   // controls for one column read-modify-write
   typedef struct packed {
      op_type     op;
      mode_type   mode;
      logic [7:0] pay;
      logic [4:0] y_first;
      logic [4:0] y_last;
      logic [4:0] blit_y;
      logic [2:0] sub_idx;
   } col_cmd_type;

   function automatic logic [47:0] glyph_cols(input logic [6:0] code);
      logic [47:0] g;
      case (code)
         7'd0:  g = 48'h000000000000;  7'd1:  g = 48'h00005F000000;
         7'd2:  g = 48'h000300030000;  7'd3:  g = 48'h0A1F0A1F0A00;
         7'd4:  g = 48'h2649FF493200;  7'd5:  g = 48'h6619374D3300;
         7'd6:  g = 48'h364955225000;  7'd7:  g = 48'h000003000000;
         7'd8:  g = 48'h003E41800000;  7'd9:  g = 48'h0080413E0000;
         7'd10: g = 48'h0A041F040A00;  7'd11: g = 48'h08083E080800;
         7'd12: g = 48'h0060E0000000;  7'd13: g = 48'h000808080000;
         7'd14: g = 48'h000060600000;  7'd15: g = 48'h806018060100;
         7'd16: g = 48'h3E5149453E00;  7'd17: g = 48'h42427F404000;
         7'd18: g = 48'h426151494600;  7'd19: g = 48'h224149493600;
         7'd20: g = 48'h1814527F5000;  7'd21: g = 48'h274545453900;
         7'd22: g = 48'h3E4545453800;  7'd23: g = 48'h010171090700;
         7'd24: g = 48'h364949493600;  7'd25: g = 48'h0E5151513E00;
         7'd26: g = 48'h00006C6C0000;  7'd27: g = 48'h006CEC000000;
         7'd28: g = 48'h000814224100;  7'd29: g = 48'h141414141400;
         7'd30: g = 48'h004122140800;  7'd31: g = 48'h020151090600;
         7'd32: g = 48'h3E415D555E00;  7'd33: g = 48'h781611167800;
         7'd34: g = 48'h7F4949493600;  7'd35: g = 48'h3E4141412200;
         7'd36: g = 48'h7F4141413E00;  7'd37: g = 48'h7F4949494100;
         7'd38: g = 48'h7F0909090100;  7'd39: g = 48'h3E4141493A00;
         7'd40: g = 48'h7F0808087F00;  7'd41: g = 48'h41417F414100;
         7'd42: g = 48'h304040403F00;  7'd43: g = 48'h7F0814224100;
         7'd44: g = 48'h7F4040404000;  7'd45: g = 48'h7F020C027F00;
         7'd46: g = 48'h7F0204087F00;  7'd47: g = 48'h3E4141413E00;
         7'd48: g = 48'h7F0909090600;  7'd49: g = 48'h3E416141BE00;
         7'd50: g = 48'h7F0909097600;  7'd51: g = 48'h264949493200;
         7'd52: g = 48'h01017F010100;  7'd53: g = 48'h3F4040403F00;
         7'd54: g = 48'h071860180700;  7'd55: g = 48'h7F2018207F00;
         7'd56: g = 48'h631408146300;  7'd57: g = 48'h070870080700;
         7'd58: g = 48'h615149454300;  7'd59: g = 48'h0000FF800000;
         7'd60: g = 48'h000106186080;  7'd61: g = 48'h0080FF000000;
         7'd62: g = 48'h040201020400;  7'd63: g = 48'h000000000000;
         7'd64: g = 48'h000001000000;  7'd65: g = 48'h384444247C00;
         7'd66: g = 48'h7F4444443800;  7'd67: g = 48'h384444444800;
         7'd68: g = 48'h384444447F00;  7'd69: g = 48'h385454545800;
         7'd70: g = 48'h00047E050100;  7'd71: g = 48'h38444444FC00;
         7'd72: g = 48'h7F0404047800;  7'd73: g = 48'h00447D400000;
         7'd74: g = 48'h0004FD000000;  7'd75: g = 48'h7F1018244000;
         7'd76: g = 48'h00417F400000;  7'd77: g = 48'h7C047C047800;
         7'd78: g = 48'h7C0804047800;  7'd79: g = 48'h384444443800;
         7'd80: g = 48'hFC4444443800;  7'd81: g = 48'h38444444FC00;
         7'd82: g = 48'h7C0804040800;  7'd83: g = 48'h485454542400;
         7'd84: g = 48'h00043F444000;  7'd85: g = 48'h3C4040207C00;
         7'd86: g = 48'h0C3040300C00;  7'd87: g = 48'h3C403C403C00;
         7'd88: g = 48'h442810284400;  7'd89: g = 48'h3C20A0A0FC00;
         7'd90: g = 48'h4464544C4400;  7'd91: g = 48'h0008F7000000;
         7'd92: g = 48'h0000FF000000;  7'd93: g = 48'h0000F7080000;
         7'd94: g = 48'h08040C080400;
         default: g = 48'h000000000000;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] glyph_byte(input logic [6:0] code, input logic [2:0] col);
      logic [47:0] g;
      logic [7:0]  b;
      g = glyph_cols(code);
      case (col)
         3'd0: b = g[47:40];
         3'd1: b = g[39:32];
         3'd2: b = g[31:24];
         3'd3: b = g[23:16];
         3'd4: b = g[15:8];
         3'd5: b = g[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### design/fbde_chan_if.sv
// request and response channel interfaces
interface fbde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [6:0] x_first;
   logic [6:0] x_last;
   logic [4:0] y_first;
   logic [4:0] y_last;
   logic [6:0] img_width;
   logic [5:0] img_height;
   logic [1:0] draw_mode;
   logic [7:0] payload;
   logic       image_start;

   modport source (output valid, operation, x_first, x_last, y_first, y_last,
                   img_width, img_height, draw_mode, payload, image_start,
                   input ready);
   modport sink   (input valid, operation, x_first, x_last, y_first, y_last,
                   img_width, img_height, draw_mode, payload, image_start,
                   output ready);
endinterface

interface fbde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] column_word;
   logic [7:0]  next_column;
   logic [1:0]  status;

   modport source (output valid, column_word, next_column, status, input ready);
   modport sink   (input valid, column_word, next_column, status, output ready);
endinterface

### design/fbde_ram.sv
// generic single-port-write ram with registered read
module fbde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### design/fbde_col_alu.sv
// column word update unit shared by all drawing commands
module fbde_col_alu (
   input  fbde_pkg::col_cmd_type cmd,
   input  logic [31:0]           old_word,
   output logic [31:0]           new_word
);
   logic [31:0] band;
   logic [31:0] pix;
   logic [31:0] glyph;
   logic [31:0] win;
   logic        src_bit;

   always_comb begin
      if (cmd.y_first > cmd.y_last) begin
         band = 32'd0;
      end else begin
         band = (32'hFFFF_FFFF << cmd.y_first) & (32'hFFFF_FFFF >> (5'd31 - cmd.y_last));
      end
      pix     = 32'd1 << cmd.blit_y;
      src_bit = cmd.pay[3'd7 - cmd.sub_idx];
      // glyph byte and its window shift down the column, rows past 31 drop
      glyph   = {24'd0, fbde_pkg::glyph_byte(cmd.pay[6:0] - 7'd32, cmd.sub_idx)} << cmd.y_first;
      win     = 32'h0000_00FF << cmd.y_first;
      new_word = old_word;
      unique case (cmd.op)
         fbde_pkg::OP_BLIT: begin
            unique case (cmd.mode)
               fbde_pkg::MODE_SET:    new_word = src_bit ? (old_word | pix) : (old_word & ~pix);
               fbde_pkg::MODE_CLEAR:  new_word = old_word & ~pix;
               fbde_pkg::MODE_XOR:    new_word = src_bit ? (old_word ^ pix) : old_word;
               fbde_pkg::MODE_INVERT: new_word = src_bit ? (old_word & ~pix) : (old_word | pix);
               default:               new_word = old_word;
            endcase
         end
         fbde_pkg::OP_CHAR: begin
            if (cmd.mode == fbde_pkg::MODE_SET) begin
               new_word = (old_word & ~win) | glyph;
            end else if (cmd.mode == fbde_pkg::MODE_INVERT) begin
               new_word = (old_word | win) & ~glyph;
            end
         end
         fbde_pkg::OP_BAND:  new_word = (cmd.pay == 8'd0) ? (old_word & ~band) : (old_word | band);
         fbde_pkg::OP_HLINE: new_word = old_word | (32'd1 << cmd.y_first);
         fbde_pkg::OP_VLINE: new_word = band;
         fbde_pkg::OP_FILL:  new_word = {4{cmd.pay}};
         default:            new_word = old_word;
      endcase
   end
endmodule

### design/mono_page_framebuffer_draw_engine.sv
// framebuffer draw engine top: sequencer, cursor, column store and response register
//
//  channel   dir  handshake     contents
//  req_ch    in   valid/ready   drawing command and its operands
//  rsp_ch    out  valid/ready   column word, next column, status
//
// each request walks its columns one at a time through the shared update unit:
// a setup state, then a ram read state and a modify/write state per column, then a
// finish state that waits until the response register is free, then back to idle.
// reset blanks the panel at once through per-column valid bits, no clearing pass.
// a new request is taken only when idle; a finished response waits in its register.
module mono_page_framebuffer_draw_engine (
   input logic       clock,
   input logic       reset,
   fbde_req_if.sink   req_ch,
   fbde_rsp_if.source rsp_ch
);
   fbde_pkg::state_type state_ff, state_in;

   fbde_pkg::op_type   op_ff;
   fbde_pkg::mode_type mode_ff;
   logic [6:0] x0_ff, x1_ff, w_ff;
   logic [4:0] y0_ff, y1_ff;
   logic [5:0] h_ff;
   logic [7:0] pay_ff;
   logic       start_ff;

   logic [8:0] base_ff, base_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] idx_ff, idx_in;
   logic [5:0] blit_y_ff, blit_y_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] word_ff, word_in;
   logic [7:0] next_ff, next_in;
   logic [4:0] blit_row_ff, blit_row_in;
   logic [6:0] blit_col_ff, blit_col_in;
   logic [fbde_pkg::COLUMNS-1:0] col_valid_ff, col_valid_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic [7:0]  rsp_next_ff;
   logic [1:0]  rsp_status_ff;

   logic accept, rsp_load;
   logic ram_rd_en, ram_wr_en;
   logic [31:0] ram_rd_data, old_word, new_word;
   logic [8:0]  col_x;
   logic [fbde_pkg::COL_AW-1:0] col_addr;
   logic        in_range;
   fbde_pkg::col_cmd_type cmd;

   logic [4:0] cur_row;
   logic [6:0] cur_col;
   logic [7:0] remain;
   logic [3:0] n_cols;
   logic [7:0] col_sum;
   logic       char_ok;

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == fbde_pkg::S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   assign col_x    = base_ff + {1'b0, idx_ff};
   assign col_addr = col_x[fbde_pkg::COL_AW-1:0];
   assign in_range = (col_x < 9'(fbde_pkg::COLUMNS)) &&
                     ((op_ff != fbde_pkg::OP_BLIT) || (blit_y_ff < 6'(fbde_pkg::ROWS)));
   assign old_word = col_valid_ff[col_addr] ? ram_rd_data : 32'd0;

   assign cmd.op      = op_ff;
   assign cmd.mode    = mode_ff;
   assign cmd.pay     = pay_ff;
   assign cmd.y_first = y0_ff;
   assign cmd.y_last  = y1_ff;
   assign cmd.blit_y  = blit_y_ff[4:0];
   assign cmd.sub_idx = idx_ff[2:0];

   fbde_col_alu u_alu (
      .cmd      (cmd),
      .old_word (old_word),
      .new_word (new_word)
   );

   fbde_ram #(
      .WIDTH (32),
      .DEPTH (fbde_pkg::COLUMNS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (col_addr),
      .wr_data (new_word),
      .rd_en   (ram_rd_en),
      .rd_addr (col_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbde_pkg::S_IDLE:   if (accept) state_in = fbde_pkg::S_LOAD;
         fbde_pkg::S_LOAD:   state_in = (cnt_in == 8'd0) ? fbde_pkg::S_FINISH : fbde_pkg::S_READ;
         fbde_pkg::S_READ:   state_in = fbde_pkg::S_MODIFY;
         fbde_pkg::S_MODIFY: state_in = (idx_ff + 8'd1 == cnt_ff) ? fbde_pkg::S_FINISH
                                                                 : fbde_pkg::S_READ;
         fbde_pkg::S_FINISH: if (rsp_load) state_in = fbde_pkg::S_IDLE;
         default:            state_in = fbde_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready = (state_ff == fbde_pkg::S_IDLE);
      ram_rd_en    = (state_ff == fbde_pkg::S_READ);
      ram_wr_en    = (state_ff == fbde_pkg::S_MODIFY) && in_range && (op_ff != fbde_pkg::OP_READ);
   end

   // command setup and per-column bookkeeping
   always_comb begin
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      blit_y_in    = blit_y_ff;
      status_in    = status_ff;
      word_in      = word_ff;
      next_in      = next_ff;
      blit_row_in  = blit_row_ff;
      blit_col_in  = blit_col_ff;
      col_valid_in = col_valid_ff;

      cur_row = start_ff ? 5'd0 : blit_row_ff;
      cur_col = start_ff ? 7'd0 : blit_col_ff;
      remain  = (w_ff > cur_col) ? ({1'b0, w_ff} - {1'b0, cur_col}) : 8'd0;
      n_cols  = (remain > 8'd8) ? 4'd8 : remain[3:0];
      col_sum = {1'b0, cur_col} + {4'd0, n_cols};
      char_ok = !pay_ff[7] && (pay_ff[6:5] != 2'b00);

      if (state_ff == fbde_pkg::S_LOAD) begin
         idx_in    = 8'd0;
         status_in = fbde_pkg::ST_OK;
         word_in   = 32'd0;
         next_in   = 8'd0;
         base_in   = {2'b00, x0_ff};
         blit_y_in = {1'b0, y0_ff} + {1'b0, cur_row};
         unique case (op_ff) inside
            fbde_pkg::OP_BLIT: begin
               base_in = {2'b00, x0_ff} + {2'b00, cur_col};
               cnt_in  = {4'd0, n_cols};
               if (col_sum >= {1'b0, w_ff}) begin
                  blit_col_in = 7'd0;
                  blit_row_in = ({1'b0, cur_row} + 6'd1 >= h_ff) ? 5'd0 : cur_row + 5'd1;
               end else begin
                  blit_col_in = col_sum[6:0];
                  blit_row_in = cur_row;
               end
            end
            fbde_pkg::OP_CHAR: begin
               if (char_ok) begin
                  cnt_in  = 8'(fbde_pkg::GLYPH_WIDTH);
                  next_in = {1'b0, x0_ff} + 8'(fbde_pkg::GLYPH_WIDTH);
               end else begin
                  cnt_in    = 8'd0;
                  next_in   = {1'b0, x0_ff};
                  status_in = fbde_pkg::ST_BAD_CHAR;
               end
            end
            fbde_pkg::OP_BAND, fbde_pkg::OP_HLINE: begin
               cnt_in = (x0_ff <= x1_ff) ? ({1'b0, x1_ff} - {1'b0, x0_ff} + 8'd1) : 8'd0;
            end
            fbde_pkg::OP_VLINE, fbde_pkg::OP_READ: cnt_in = 8'd1;
            fbde_pkg::OP_FILL: begin
               base_in = 9'd0;
               cnt_in  = 8'(fbde_pkg::COLUMNS);
            end
            default: cnt_in = 8'd0;
         endcase
      end

      if (state_ff == fbde_pkg::S_MODIFY) begin
         idx_in = idx_ff + 8'd1;
         if (!in_range) begin
            status_in = fbde_pkg::ST_CLIPPED;
         end else if (op_ff == fbde_pkg::OP_READ) begin
            word_in = old_word;
         end else begin
            col_valid_in[col_addr] = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbde_pkg::S_IDLE;
         blit_row_ff  <= 5'd0;
         blit_col_ff  <= 7'd0;
         col_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blit_row_ff  <= blit_row_in;
         blit_col_ff  <= blit_col_in;
         col_valid_ff <= col_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= fbde_pkg::op_type'(req_ch.operation);
         mode_ff  <= fbde_pkg::mode_type'(req_ch.draw_mode);
         x0_ff    <= req_ch.x_first;
         x1_ff    <= req_ch.x_last;
         y0_ff    <= req_ch.y_first;
         y1_ff    <= req_ch.y_last;
         w_ff     <= req_ch.img_width;
         h_ff     <= req_ch.img_height;
         pay_ff   <= req_ch.payload;
         start_ff <= req_ch.image_start;
      end
      base_ff   <= base_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      blit_y_ff <= blit_y_in;
      status_ff <= status_in;
      word_ff   <= word_in;
      next_ff   <= next_in;
      if (rsp_load) begin
         rsp_word_ff   <= word_ff;
         rsp_next_ff   <= next_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.column_word = rsp_word_ff;
   assign rsp_ch.next_column = rsp_next_ff;
   assign rsp_ch.status      = rsp_status_ff;
endmodule
